[hdl/csd_pkg.sv]
package csd_pkg;

    localparam int MAX_SPAN   = 1024;
    localparam int LINE_WIDTH = 20;
    localparam int LEN_W      = $clog2(MAX_SPAN);
    localparam int START_W    = 20;

    localparam logic [LEN_W-1:0]      LEN_LIMIT = LEN_W'(MAX_SPAN - 1);
    localparam logic [LINE_WIDTH-1:0] LINE_MAX  = {LINE_WIDTH{1'b1}};

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;

    // distance of the first letter behind the current byte
    localparam logic [1:0] LD_NONE = 2'd0;
    localparam logic [1:0] LD_ONE  = 2'd1;
    localparam logic [1:0] LD_FAR  = 2'd2;

    localparam logic [2:0] RUN_FULL = 3'd4;

    typedef struct packed {
        logic [1:0] letter_dist;
        logic [2:0] run;
        logic       found;
        logic       op;
        logic       nul;
    } t_match;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               byte_valid;
        logic               span_end;
        logic               is_cite;
        logic [START_W-1:0] start_line;
    } t_result;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39);
    endfunction

endpackage

[hdl/csd_byte_if.sv]
interface csd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

[hdl/csd_res_if.sv]
interface csd_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        span_end;
    logic        is_cite;
    logic [19:0] start_line;

    modport source (
        output valid, output out_byte, output byte_valid, output span_end,
        output is_cite, output start_line, input ready
    );
    modport sink (
        input valid, input out_byte, input byte_valid, input span_end,
        input is_cite, input start_line, output ready
    );
endinterface

[hdl/csd_inreg.sv]
module csd_inreg
    import csd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    csd_byte_if.sink   i_in,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign i_in.ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_byte     = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.in_byte;
        end
    end

endmodule

[hdl/csd_scan.sv]
module csd_scan
    import csd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    output logic       o_has_result,
    output t_result    o_result
);

    logic                  r_in_span;
    logic [LEN_W-1:0]      r_len;
    logic [LINE_WIDTH-1:0] r_line;
    logic [LINE_WIDTH-1:0] r_start;
    t_match                r_match;

    logic                  n_in_span;
    logic [LEN_W-1:0]      n_len;
    logic [LINE_WIDTH-1:0] n_line;
    logic [LINE_WIDTH-1:0] n_start;
    t_match                n_match;

    logic                  open_span;
    logic                  active;
    logic                  room;
    logic                  closing;
    logic [7:0]            shown;
    t_match                fed;
    logic [START_W+LINE_WIDTH-1:0] start_ext;

    function automatic t_match feed(input t_match m, input logic [7:0] b);
        t_match r;
        logic   elig;
        r    = m;
        elig = (m.letter_dist == LD_FAR);
        if (!m.nul) begin
            if (b == CH_NUL) begin
                r.nul = 1'b1;
            end else begin
                if (b == CH_EQ || b == CH_LT || b == CH_GT || b == CH_PLUS) begin
                    r.op = 1'b1;
                end
                if (is_digit(b) && elig) begin
                    if (m.run < RUN_FULL) begin
                        r.run = m.run + 3'd1;
                    end
                    if (r.run == RUN_FULL) begin
                        r.found = 1'b1;
                    end
                end else begin
                    r.run = '0;
                end
                if (m.letter_dist == LD_ONE) begin
                    r.letter_dist = LD_FAR;
                end else if (m.letter_dist == LD_NONE && is_letter(b)) begin
                    r.letter_dist = LD_ONE;
                end
            end
        end
        return r;
    endfunction

    always_comb begin
        open_span = (i_byte == CH_OPEN);
        active    = r_in_span || open_span;
        room      = (r_len < LEN_LIMIT);
        closing   = active && (!room || i_byte == CH_CLOSE);
        shown     = '0;
        if (room) begin
            shown = (i_byte == CH_NL) ? CH_SPACE : i_byte;
        end
        fed = room ? feed(r_match, shown) : r_match;

        n_start = open_span ? r_line : r_start;
        n_line  = r_line;
        if (i_byte == CH_NL && r_line != LINE_MAX) begin
            n_line = r_line + LINE_WIDTH'(1);
        end

        n_in_span = r_in_span;
        n_len     = r_len;
        n_match   = r_match;
        if (closing) begin
            n_in_span = 1'b0;
            n_len     = '0;
            n_match   = '0;
        end else if (active) begin
            n_in_span = 1'b1;
            n_len     = r_len + LEN_W'(1);
            n_match   = fed;
        end
    end

    // start line shown through its low bits, zero filled for narrow counts
    assign start_ext = {{START_W{1'b0}}, n_start};

    assign o_has_result        = active;
    assign o_result.out_byte   = shown;
    assign o_result.byte_valid = room;
    assign o_result.span_end   = closing;
    assign o_result.is_cite    = closing && fed.found && !fed.op;
    assign o_result.start_line = start_ext[START_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_span <= 1'b0;
            r_len     <= '0;
            r_line    <= LINE_WIDTH'(1);
            r_start   <= LINE_WIDTH'(1);
            r_match   <= '0;
        end else if (i_fire) begin
            r_in_span <= n_in_span;
            r_len     <= n_len;
            r_line    <= n_line;
            r_start   <= n_start;
            r_match   <= n_match;
        end
    end

endmodule

[hdl/csd_outreg.sv]
module csd_outreg
    import csd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_result    i_result,
    output logic       o_room,
    csd_res_if.source  o_out
);

    logic    r_valid;
    t_result r_result;

    assign o_room           = !r_valid || o_out.ready;
    assign o_out.valid      = r_valid;
    assign o_out.out_byte   = r_result.out_byte;
    assign o_out.byte_valid = r_result.byte_valid;
    assign o_out.span_end   = r_result.span_end;
    assign o_out.is_cite    = r_result.is_cite;
    assign o_out.start_line = r_result.start_line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

[hdl/citation_span_detector_top.sv]
// Citation span detector: takes one text byte per beat and returns a result beat for every
// byte that falls inside a parenthesised span, with a closing beat that flags the span as
// a likely citation. Bytes outside a span give no result. The block sustains one byte per
// clock while the output side is not stalling: a byte passes an input register, is scanned
// against a few registers of running state (span flag, line count, start line, span length
// and the match automaton), and its result lands in an output register. A byte with no
// result never waits for the output side; a span byte waits in the input register while an
// earlier result is held and not taken.
module citation_span_detector_top
    import csd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    csd_byte_if.sink  i_in,
    csd_res_if.source o_out
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       take;
    logic       has_result;
    logic       out_room;
    t_result    result;

    // a byte with no result never waits for the output side
    assign take = in_valid && (!has_result || out_room);

    csd_inreg u_inreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    csd_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (take),
        .i_byte       (in_byte),
        .o_has_result (has_result),
        .o_result     (result)
    );

    csd_outreg u_outreg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take && has_result),
        .i_result (result),
        .o_room   (out_room),
        .o_out    (o_out)
    );

endmodule

[test/citation_span_detector_top_tb.sv]
module citation_span_detector_top_tb;
    import csd_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 4;
    localparam int TOTAL_BYTES    = 1200;
    localparam int TAIL_BYTES     = 20;
    localparam int QUIET_BYTES    = 60;
    localparam int DRAIN_CYCLES   = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LIMIT_TIME     = 5_000_000;
    localparam logic [2:0] RUN_LEN = 3'd4;

    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_NL    = 8'h0A;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_OPEN  = 8'h28;
    localparam logic [7:0] CHR_CLOSE = 8'h29;
    localparam logic [7:0] CHR_COMMA = 8'h2C;

    localparam logic [LEN_W-1:0]      HELD_TOP = LEN_W'(MAX_SPAN - 1);
    localparam logic [LINE_WIDTH-1:0] LINE_TOP = {LINE_WIDTH{1'b1}};

    typedef enum logic [1:0] {
        NO_LETTER     = 2'd0,
        LETTER_BEHIND = 2'd1,
        LETTER_FAR    = 2'd2
    } t_letter_dist;

    class cite_scoreboard;
        bit                    in_span;
        logic [LEN_W-1:0]      held;
        logic [LINE_WIDTH-1:0] line_no;
        logic [LINE_WIDTH-1:0] span_line;
        t_letter_dist          letter_dist;
        logic [2:0]            digit_run;
        bit                    found;
        bit                    op_seen;
        bit                    nul_seen;
        t_result               due_results[$];
        int                    errors;
        int                    checked;
        int                    predicted;
        int                    spans_closed;
        int                    cite_count;
        int                    overflows;

        function new();
            in_span      = 1'b0;
            held         = '0;
            line_no      = LINE_WIDTH'(1);
            span_line    = LINE_WIDTH'(1);
            errors       = 0;
            checked      = 0;
            predicted    = 0;
            spans_closed = 0;
            cite_count   = 0;
            overflows    = 0;
            clear_matcher();
        endfunction

        function void clear_matcher();
            letter_dist = NO_LETTER;
            digit_run   = '0;
            found       = 1'b0;
            op_seen     = 1'b0;
            nul_seen    = 1'b0;
        endfunction

        function void feed_cite_matcher(logic [7:0] b);
            bit letter;
            bit digit;
            bit eligible;
            letter = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
            digit  = (b >= 8'h30 && b <= 8'h39);
            // everything after a nul is echoed but never matched
            if (nul_seen)
                return;
            if (b == CHR_NUL) begin
                nul_seen = 1'b1;
                return;
            end
            if (b inside {CH_EQ, CH_LT, CH_GT, CH_PLUS})
                op_seen = 1'b1;
            eligible = (letter_dist == LETTER_FAR);
            if (digit && eligible) begin
                if (digit_run < RUN_LEN)
                    digit_run++;
                if (digit_run == RUN_LEN)
                    found = 1'b1;
            end else begin
                digit_run = '0;
            end
            if (letter_dist == LETTER_BEHIND)
                letter_dist = LETTER_FAR;
            else if (letter_dist == NO_LETTER && letter)
                letter_dist = LETTER_BEHIND;
        endfunction

        function void note_byte(logic [7:0] b);
            t_result r;
            r = '0;
            if (b == CHR_OPEN) begin
                in_span   = 1'b1;
                span_line = line_no;
            end
            if (b == CHR_NL && line_no != LINE_TOP)
                line_no++;
            if (!in_span)
                return;
            if (held < HELD_TOP) begin
                r.out_byte   = (b == CHR_NL) ? CHR_SPACE : b;
                r.byte_valid = 1'b1;
                held++;
                feed_cite_matcher(r.out_byte);
            end else begin
                // full span: this byte is dropped and the span cut
                in_span = 1'b0;
                overflows++;
            end
            if (b == CHR_CLOSE)
                in_span = 1'b0;
            if (!in_span) begin
                r.span_end = 1'b1;
                r.is_cite  = found && !op_seen;
                spans_closed++;
                if (r.is_cite)
                    cite_count++;
                held = '0;
                clear_matcher();
            end
            r.start_line = span_line[START_W-1:0];
            due_results.push_back(r);
            predicted++;
        endfunction

        function void check_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual 0x%0h",
                         $time, got);
                errors++;
                return;
            end
            want = due_results.pop_front();
            checked++;
            check_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
            check_field("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
            check_field("span_end", 32'(want.span_end), 32'(got.span_end));
            check_field("is_cite", 32'(want.is_cite), 32'(got.is_cite));
            check_field("start_line", 32'(want.start_line), 32'(got.start_line));
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic sink_ready = 1'b0;
    bit   idling_on  = 1'b1;
    int   stall_left = 0;
    int   bytes_sent = 0;

    cite_scoreboard sb;
    t_result        seen_result;

    csd_byte_if byte_if ();
    csd_res_if  res_if ();

    assign res_if.ready = sink_ready;

    citation_span_detector_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_if),
        .o_out   (res_if)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // result side back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            sink_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idling_on && $urandom_range(0, 4) == 0) begin
            sink_ready <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end else begin
            sink_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                seen_result = {res_if.out_byte, res_if.byte_valid, res_if.span_end,
                               res_if.is_cite, res_if.start_line};
                sb.check_result(seen_result);
            end
            if (byte_if.valid && byte_if.ready)
                sb.note_byte(byte_if.in_byte);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            byte_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_if.valid   <= 1'b1;
        byte_if.in_byte <= b;
        do
            @(posedge i_clk);
        while (!byte_if.ready);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] random_letter();
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] random_digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] byte_other_than(input logic [7:0] skip);
        logic [7:0] b;
        b = 8'($urandom_range(0, 254));
        if (b >= skip)
            b = b + 8'd1;
        return b;
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(0, 3))
            0:       return CH_EQ;
            1:       return CH_LT;
            2:       return CH_GT;
            default: return CH_PLUS;
        endcase
    endfunction

    // bytes just outside the letter and digit ranges
    function automatic logic [7:0] near_miss();
        case ($urandom_range(0, 5))
            0:       return 8'h40;
            1:       return 8'h5B;
            2:       return 8'h60;
            3:       return 8'h7B;
            4:       return 8'h2F;
            default: return 8'h3A;
        endcase
    endfunction

    function automatic logic [7:0] filler_byte();
        case ($urandom_range(0, 3))
            0:       return random_letter();
            1:       return random_digit();
            2:       return CHR_SPACE;
            default: return CHR_NL;
        endcase
    endfunction

    task automatic send_piece();
        case ($urandom_range(0, 11))
            0, 1, 2: repeat ($urandom_range(1, 5)) send_byte(random_letter());
            3:       send_byte(CHR_SPACE);
            4, 5:    repeat (RUN_LEN) send_byte(random_digit());
            6:       send_byte(CHR_NL);
            7:       send_byte($urandom_range(0, 2) == 0 ? random_operator() : CHR_COMMA);
            8:       send_byte(byte_other_than(CHR_CLOSE));
            9:       send_byte(near_miss());
            10:      send_byte($urandom_range(0, 3) == 0 ? CHR_NUL : CHR_OPEN);
            default: repeat ($urandom_range(1, 6)) send_byte(random_digit());
        endcase
    endtask

    task automatic send_random_span();
        int pieces;
        pieces = $urandom_range(0, 6);
        send_byte(CHR_OPEN);
        repeat (pieces) send_piece();
        // now and then leave the span open so the next one runs on
        if ($urandom_range(0, 9) != 0)
            send_byte(CHR_CLOSE);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 3) == 0)
                send_byte(CHR_NL);
            else
                send_byte(byte_other_than(CHR_OPEN));
        end
    endtask

    task automatic send_long_span(input int filler_len, input logic [7:0] tail);
        send_byte(CHR_OPEN);
        repeat (filler_len) send_byte(filler_byte());
        send_byte(tail);
    endtask

    initial begin
        int waited;
        sb = new();
        byte_if.valid   = 1'b0;
        byte_if.in_byte = 8'h00;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // outside a span, then the match boundaries, operator, restart and nul
        send_byte(8'hFF);
        send_byte(CHR_NL);
        send_text("(A2019)");
        send_text("(Ab2019)");
        send_text("(a=2468)");
        send_text("(\n(");
        send_byte(CHR_NUL);
        send_byte(CHR_CLOSE);

        // span filled to the limit, then cut by a '(' that still moves the start line
        send_long_span(MAX_SPAN - 2, CHR_OPEN);
        send_byte(CHR_CLOSE);

        while (bytes_sent < TOTAL_BYTES - TAIL_BYTES) begin
            if (bytes_sent > TOTAL_BYTES - QUIET_BYTES)
                idling_on = 1'b0;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: send_random_span();
                7, 8:                send_noise();
                default: repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            endcase
        end

        // close anything left open, then a few fixed spans at full rate
        send_byte(CHR_CLOSE);
        idling_on = 1'b0;
        send_text("(Xy 1066)");
        send_text("(\n(a)");
        byte_if.valid <= 1'b0;

        waited = 0;
        while (sb.due_results.size() != 0 && waited < DRAIN_CYCLES) begin
            @(posedge i_clk);
            waited++;
        end
        if (sb.due_results.size() != 0) begin
            $display("%0t: timed out with %0d results outstanding",
                     $time, sb.due_results.size());
            sb.errors++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.due_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived",
                     $time, sb.due_results.size());
            sb.errors++;
        end

        $display("run covered %0d text bytes and %0d result beats checked",
                 bytes_sent, sb.checked);
        $display("%0d spans closed, %0d flagged as citations, %0d cut at full length",
                 sb.spans_closed, sb.cite_count, sb.overflows);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #(LIMIT_TIME);
        $display("%0t: watchdog expired", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[citation_span_detector_top.f]
hdl/csd_pkg.sv
hdl/csd_byte_if.sv
hdl/csd_res_if.sv
hdl/csd_inreg.sv
hdl/csd_scan.sv
hdl/csd_outreg.sv
hdl/citation_span_detector_top.sv
test/citation_span_detector_top_tb.sv
